FILE: rtl/mctm_pkg.sv
// mctm_pkg: shared types, codes and constants of the MIDI clock tempo meter.
// Used by every module of the block and by its port checker.
`timescale 1ns / 1ps

package mctm_pkg;

  // Free-running millisecond counter width
  localparam int TIME_BITS = 32;

  localparam int FUNC_W  = 2;
  localparam int MSG_W   = 8;
  localparam int DELTA_W = 7;
  localparam int KIND_W  = 2;
  localparam int BPM_W   = 24;
  localparam int REQ_W   = 25;
  localparam int CC_W    = 7;
  localparam int CH_W    = 5;
  localparam int CPM_W   = 8;

  localparam int IN_DATA_W  = 16;  // message_type + bpm_change, byte padded
  localparam int OUT_DATA_W = 72;  // five result fields, byte padded

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Input item kinds
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_MIDI  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TEMPO = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TEMPO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CC    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPM     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CC = 3'd4;

  // Configuration reset values
  localparam logic [CH_W-1:0]  RST_CHANNEL = 5'd2;
  localparam logic [CPM_W-1:0] RST_CPM     = 8'd96;
  localparam logic [BPM_W-1:0] RST_SCALE   = 24'd240110;
  localparam logic [CC_W-1:0]  RST_LOW_CC  = 7'd4;
  localparam logic [CC_W-1:0]  RST_HIGH_CC = 7'd5;

  localparam logic [MSG_W-1:0] CLOCK_STATUS = 8'hF8;
  localparam logic [BPM_W-1:0] MAX_BPM      = 24'hFFFFFF;

  // Tempo request bounds, one bit wider than the request field
  localparam logic signed [REQ_W:0] MAX_REQ   = 26'sd16777215;
  localparam logic signed [REQ_W:0] LOW_BASE  = 26'sd40;
  localparam logic signed [REQ_W:0] SPLIT_BPM = 26'sd160;
  localparam logic signed [REQ_W:0] HIGH_TOP  = 26'sd287;

  // Divider: one quotient bit per cycle
  localparam int DIV_STEPS = BPM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [CPM_W-1:0] clocks_per_measure;
    logic [BPM_W-1:0] tempo_scale;
    logic [CC_W-1:0]  low_cc;
    logic [CC_W-1:0]  high_cc;
  } cfg_t;

  typedef enum logic {
    CMD_MEASURE,
    CMD_TEMPO
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [TIME_BITS-1:0] elapsed;
    logic [DELTA_W-1:0]   delta;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BPM_W-1:0]  measured_bpm;
    logic [REQ_W-1:0]  requested_bpm;
    logic [CC_W-1:0]   cc_number;
    logic [CC_W-1:0]   cc_value;
    logic [CH_W-1:0]   cc_channel;
    logic              last;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SEND
  } back_state_t;

endpackage

FILE: rtl/mctm_front.sv
// mctm_front: accepts input items, keeps the millisecond clock and the
// clock-message count, and queues measure and tempo commands. Uses mctm_pkg.
`timescale 1ns / 1ps

module mctm_front (
  input  logic                            clk,
  input  logic                            rst,
  input  mctm_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mctm_pkg::FUNC_W-1:0]     in_func,
  input  logic [mctm_pkg::MSG_W-1:0]      in_msg,
  input  logic [mctm_pkg::DELTA_W-1:0]    in_delta,
  input  logic                            q_full,
  output logic                            q_push,
  output mctm_pkg::cmd_t                  q_cmd
);
  import mctm_pkg::*;

  logic [TIME_BITS-1:0] time_now;
  logic [TIME_BITS-1:0] start_stamp;
  logic                 measuring;
  logic [CPM_W-1:0]     clock_count;
  logic [CPM_W-1:0]     count_next;
  logic                 accept;
  logic                 is_clock;
  logic                 done_measure;

  assign in_ready     = !q_full;
  assign accept       = in_valid && in_ready;
  assign is_clock     = (in_func == FUNC_MIDI) && (in_msg == CLOCK_STATUS);
  assign count_next   = clock_count + CPM_W'(1);
  assign done_measure = measuring && (count_next >= cfg.clocks_per_measure);

  always_comb begin
    q_push        = 1'b0;
    q_cmd.kind    = CMD_TEMPO;
    q_cmd.elapsed = time_now - start_stamp;
    q_cmd.delta   = in_delta;
    if (accept) begin
      if (is_clock && done_measure) begin
        q_push     = 1'b1;
        q_cmd.kind = CMD_MEASURE;
      end else if (in_func == FUNC_TEMPO) begin
        q_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now    <= '0;
      start_stamp <= '0;
      measuring   <= 1'b0;
      clock_count <= '0;
    end else if (accept) begin
      if (in_func == FUNC_TICK) begin
        time_now <= time_now + TIME_BITS'(1);
      end else if (is_clock) begin
        if (!measuring) begin
          start_stamp <= time_now;
          measuring   <= 1'b1;
          clock_count <= '0;
        end else begin
          clock_count <= count_next;
          if (done_measure) begin
            measuring <= 1'b0;
          end
        end
      end
    end
  end

endmodule

FILE: rtl/mctm_cmdq.sv
// mctm_cmdq: two-entry command queue between the front and back parts.
// Uses mctm_pkg for the command type.
`timescale 1ns / 1ps

module mctm_cmdq (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mctm_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output mctm_pkg::cmd_t head_cmd
);
  import mctm_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/mctm_back.sv
// mctm_back: runs queued commands: serial tempo division, tempo request
// range check, and the registered result stage. Uses mctm_pkg.
`timescale 1ns / 1ps

module mctm_back (
  input  logic           clk,
  input  logic           rst,
  input  mctm_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  mctm_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           res_valid,
  input  logic           res_ready,
  output mctm_pkg::res_t res
);
  import mctm_pkg::*;

  back_state_t          state, state_next;
  logic [BPM_W-1:0]     tempo_value, tempo_value_next;
  logic [TIME_BITS-1:0] rem, rem_next;
  logic [TIME_BITS-1:0] divisor, divisor_next;
  logic [BPM_W-1:0]     quot, quot_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic signed [REQ_W:0] req, req_next;
  // pending results: measured, low range, high range, out of range
  logic                 pend_meas, pend_meas_next;
  logic                 pend_low, pend_low_next;
  logic                 pend_high, pend_high_next;
  logic                 pend_oor, pend_oor_next;
  logic                 res_valid_next;
  res_t                 res_next;

  logic [TIME_BITS:0]    trial;
  logic                  trial_ge;
  logic signed [REQ_W:0] req_sum;
  logic signed [REQ_W:0] req_sat;
  logic                  slot_free;

  assign trial    = {rem, quot[BPM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor});
  assign req_sum  = $signed({2'b00, tempo_value})
                  + $signed({{(REQ_W + 1 - DELTA_W){cmd.delta[DELTA_W-1]}}, cmd.delta});
  assign req_sat  = (req_sum > MAX_REQ) ? MAX_REQ : req_sum;
  assign slot_free = !res_valid || res_ready;

  always_comb begin
    state_next       = state;
    tempo_value_next = tempo_value;
    rem_next         = rem;
    divisor_next     = divisor;
    quot_next        = quot;
    div_cnt_next     = div_cnt;
    req_next         = req;
    pend_meas_next   = pend_meas;
    pend_low_next    = pend_low;
    pend_high_next   = pend_high;
    pend_oor_next    = pend_oor;
    res_valid_next   = res_valid && !res_ready;
    res_next         = res;
    cmd_pop          = 1'b0;

    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == CMD_MEASURE) begin
            if (cmd.elapsed == '0) begin
              tempo_value_next = MAX_BPM;
              pend_meas_next   = 1'b1;
              state_next       = B_SEND;
            end else begin
              rem_next     = '0;
              divisor_next = cmd.elapsed;
              quot_next    = cfg.tempo_scale;
              div_cnt_next = '0;
              state_next   = B_DIV;
            end
          end else begin
            req_next       = req_sat;
            pend_low_next  = (req_sat >= LOW_BASE) && (req_sat <= SPLIT_BPM);
            pend_high_next = (req_sat >= SPLIT_BPM) && (req_sat <= HIGH_TOP);
            pend_oor_next  = (req_sat < LOW_BASE) || (req_sat > HIGH_TOP);
            state_next     = B_SEND;
          end
        end
      end
      B_DIV: begin
        rem_next     = trial_ge ? TIME_BITS'(trial - {1'b0, divisor})
                                : trial[TIME_BITS-1:0];
        quot_next    = {quot[BPM_W-2:0], trial_ge};
        div_cnt_next = div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_LAST) begin
          tempo_value_next = {quot[BPM_W-2:0], trial_ge};
          pend_meas_next   = 1'b1;
          state_next       = B_SEND;
        end
      end
      B_SEND: begin
        if (slot_free) begin
          res_valid_next         = 1'b1;
          res_next.measured_bpm  = tempo_value;
          res_next.requested_bpm = req[REQ_W-1:0];
          res_next.cc_number     = '0;
          res_next.cc_value      = '0;
          res_next.cc_channel    = '0;
          priority if (pend_meas) begin
            pend_meas_next         = 1'b0;
            res_next.kind          = KIND_TEMPO;
            res_next.requested_bpm = '0;
          end else if (pend_low) begin
            pend_low_next       = 1'b0;
            res_next.kind       = KIND_CC;
            res_next.cc_number  = cfg.low_cc;
            res_next.cc_value   = CC_W'(req - LOW_BASE);
            res_next.cc_channel = cfg.channel;
          end else if (pend_high) begin
            pend_high_next      = 1'b0;
            res_next.kind       = KIND_CC;
            res_next.cc_number  = cfg.high_cc;
            res_next.cc_value   = CC_W'(req - SPLIT_BPM);
            res_next.cc_channel = cfg.channel;
          end else begin
            pend_oor_next = 1'b0;
            res_next.kind = KIND_RANGE;
          end
          res_next.last = !(pend_meas_next || pend_low_next || pend_high_next
                            || pend_oor_next);
          if (res_next.last) begin
            state_next = B_IDLE;
          end
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      tempo_value <= '0;
      pend_meas   <= 1'b0;
      pend_low    <= 1'b0;
      pend_high   <= 1'b0;
      pend_oor    <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      tempo_value <= tempo_value_next;
      pend_meas   <= pend_meas_next;
      pend_low    <= pend_low_next;
      pend_high   <= pend_high_next;
      pend_oor    <= pend_oor_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    divisor <= divisor_next;
    quot    <= quot_next;
    div_cnt <= div_cnt_next;
    req     <= req_next;
    res     <= res_next;
  end

endmodule

FILE: rtl/midi_clock_tempo_meter_top.sv
// midi_clock_tempo_meter_top: top level of the MIDI clock tempo meter.
// Instantiates mctm_front, mctm_cmdq and mctm_back; uses mctm_pkg.
`timescale 1ns / 1ps

// Measures the tempo of an incoming MIDI clock and turns tempo requests into
// control changes. Each input transaction is a millisecond tick, a received
// MIDI message, or a signed tempo change. Ticks and non-clock messages give
// nothing. Every clocks_per_measure clock messages after an opening clock,
// tempo_scale is divided by the elapsed milliseconds and one measured-tempo
// result comes out; the restoring divider makes one quotient bit per cycle
// in 24 divider steps. A tempo change gives one result, or two when the
// request is exactly 160. A two-entry command queue sits between the input
// side and the divider, so ticks and clock messages keep flowing while a
// division runs as long as the queue is not full, and a registered output
// stage holds results while the sink stalls. tlast marks the final result
// of an input item. Configuration writes must happen only while the block
// is idle.

module midi_clock_tempo_meter_top (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mctm_pkg::IN_DATA_W-1:0]      s_tdata,  // [7:0] message_type, [14:8] bpm_change
  input  logic [mctm_pkg::FUNC_W-1:0]         s_tuser,  // [1:0] func
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mctm_pkg::OUT_DATA_W-1:0]     m_tdata,  // [23:0] measured_bpm,
                                                        // [48:24] requested_bpm,
                                                        // [55:49] cc_number,
                                                        // [62:56] cc_value,
                                                        // [67:63] cc_channel
  output logic [mctm_pkg::KIND_W-1:0]         m_tuser,  // [1:0] result_kind
  output logic                                m_tlast,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [mctm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mctm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mctm_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;
  res_t res;

  // Register bank; values are masked to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel            <= RST_CHANNEL;
      cfg.clocks_per_measure <= RST_CPM;
      cfg.tempo_scale        <= RST_SCALE;
      cfg.low_cc             <= RST_LOW_CC;
      cfg.high_cc            <= RST_HIGH_CC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL: cfg.channel            <= cfg_data[CH_W-1:0];
        CFG_CPM:     cfg.clocks_per_measure <= cfg_data[CPM_W-1:0];
        CFG_SCALE:   cfg.tempo_scale        <= cfg_data[BPM_W-1:0];
        CFG_LOW_CC:  cfg.low_cc             <= cfg_data[CC_W-1:0];
        CFG_HIGH_CC: cfg.high_cc            <= cfg_data[CC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mctm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_msg   (s_tdata[MSG_W-1:0]),
    .in_delta (s_tdata[MSG_W+DELTA_W-1:MSG_W]),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_push_cmd)
  );

  mctm_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  mctm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.kind;
  assign m_tlast = res.last;
  assign m_tdata = {4'b0000, res.cc_channel, res.cc_value, res.cc_number,
                    res.requested_bpm, res.measured_bpm};

endmodule

FILE: rtl/mctm_checker.sv
// mctm_checker: port-level assertions for midi_clock_tempo_meter_top,
// attached by the bind statement at the end. Uses mctm_pkg.
`timescale 1ns / 1ps

module mctm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [mctm_pkg::OUT_DATA_W-1:0]     m_tdata,
  input logic [mctm_pkg::KIND_W-1:0]         m_tuser,
  input logic                                m_tlast
);
  import mctm_pkg::*;

  // Nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == KIND_TEMPO || m_tuser == KIND_CC
                  || m_tuser == KIND_RANGE))
    else $error("bad result kind");

  // Measured and out-of-range results are always alone
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_TEMPO || m_tuser == KIND_RANGE) |-> m_tlast)
    else $error("single result without last");

  // Control change fields are zero outside control change results
  a_cc_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_CC |-> m_tdata[67:49] == '0)
    else $error("control change fields set on non-cc result");

endmodule

bind midi_clock_tempo_meter_top mctm_checker u_mctm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: tb/sv/midi_clock_tempo_meter_top_tb.sv
// Self-checking testbench for midi_clock_tempo_meter_top: drives ticks, MIDI
// messages and tempo requests, predicts every result and checks the output stream.
// Depends on mctm_pkg and the RTL of midi_clock_tempo_meter_top.
`timescale 1ns / 1ps

module midi_clock_tempo_meter_top_tb;
  import mctm_pkg::*;

  // Function code with no meaning to the block; it must be dropped silently.
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int SETTLE_CYCLES   = 64;      // covers dispatch, the divider and output
  localparam int DRAIN_LIMIT     = 100000;
  localparam int REPORT_LIMIT    = 10;

  // Tempo predictor plus the queue of results it expects, oldest first.
  class tempo_scoreboard;
    logic [CH_W-1:0]      midi_channel;
    logic [CPM_W-1:0]     clocks_per_measure;
    logic [BPM_W-1:0]     tempo_scale;
    logic [CC_W-1:0]      low_cc;
    logic [CC_W-1:0]      high_cc;
    logic [TIME_BITS-1:0] time_now;
    logic [TIME_BITS-1:0] start_stamp;
    bit                   measuring;
    logic [CPM_W-1:0]     clock_count;
    logic [BPM_W-1:0]     tempo_value;
    res_t                 pending_results[$];
    int                   faults;

    function new();
      midi_channel       = RST_CHANNEL;
      clocks_per_measure = RST_CPM;
      tempo_scale        = RST_SCALE;
      low_cc             = RST_LOW_CC;
      high_cc            = RST_HIGH_CC;
      time_now           = '0;
      start_stamp        = '0;
      measuring          = 1'b0;
      clock_count        = '0;
      tempo_value        = '0;
      faults             = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_CHANNEL: midi_channel       = value[CH_W-1:0];
        CFG_CPM:     clocks_per_measure = value[CPM_W-1:0];
        CFG_SCALE:   tempo_scale        = value[BPM_W-1:0];
        CFG_LOW_CC:  low_cc             = value[CC_W-1:0];
        CFG_HIGH_CC: high_cc            = value[CC_W-1:0];
        default: ;
      endcase
    endfunction

    function void queue_result(logic [KIND_W-1:0] kind, int requested, logic [CC_W-1:0] ccn,
                               logic [CC_W-1:0] ccv, logic [CH_W-1:0] ch, logic last);
      res_t r;
      r.kind          = kind;
      r.measured_bpm  = tempo_value;
      r.requested_bpm = REQ_W'(requested);
      r.cc_number     = ccn;
      r.cc_value      = ccv;
      r.cc_channel    = ch;
      r.last          = last;
      pending_results.push_back(r);
    endfunction

    // One accepted input transaction: update state, queue what it must produce.
    function void take_item(logic [FUNC_W-1:0] func, logic [MSG_W-1:0] msg,
                            logic [DELTA_W-1:0] delta);
      logic [TIME_BITS-1:0] elapsed;
      int                   requested;
      bit                   in_low;
      bit                   in_high;
      case (func)
        FUNC_TICK: time_now = time_now + TIME_BITS'(1);
        FUNC_MIDI: begin
          if (msg == CLOCK_STATUS) begin
            if (!measuring) begin
              start_stamp = time_now;
              measuring   = 1'b1;
              clock_count = '0;
            end else begin
              clock_count = clock_count + CPM_W'(1);
              if (clock_count >= clocks_per_measure) begin
                elapsed     = time_now - start_stamp;
                // no time passed: quotient saturates
                tempo_value = (elapsed == 0) ? MAX_BPM
                                             : BPM_W'(TIME_BITS'(tempo_scale) / elapsed);
                measuring   = 1'b0;
                queue_result(KIND_TEMPO, 0, '0, '0, '0, 1'b1);
              end
            end
          end
        end
        FUNC_TEMPO: begin
          requested = int'(tempo_value) + int'($signed(delta));
          if (requested > int'(MAX_BPM))
            requested = int'(MAX_BPM);
          in_low  = requested >= int'(LOW_BASE) && requested <= int'(SPLIT_BPM);
          in_high = requested >= int'(SPLIT_BPM) && requested <= int'(HIGH_TOP);
          // exactly the split tempo gives both control changes, low range first
          if (in_low)
            queue_result(KIND_CC, requested, low_cc, CC_W'(requested - int'(LOW_BASE)),
                         midi_channel, !in_high);
          if (in_high)
            queue_result(KIND_CC, requested, high_cc, CC_W'(requested - int'(SPLIT_BPM)),
                         midi_channel, 1'b1);
          if (!in_low && !in_high)
            queue_result(KIND_RANGE, requested, '0, '0, '0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        if (faults < REPORT_LIMIT)
          $display("%0t unexpected result: kind %0d bpm %0d req %0d", $realtime,
                   got.kind, got.measured_bpm, $signed(got.requested_bpm));
        faults++;
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.measured_bpm !== want.measured_bpm ||
          got.requested_bpm !== want.requested_bpm || got.cc_number !== want.cc_number ||
          got.cc_value !== want.cc_value || got.cc_channel !== want.cc_channel ||
          got.last !== want.last) begin
        if (faults < REPORT_LIMIT) begin
          $write("%0t mismatch (expected/actual): kind %0d/%0d bpm %0d/%0d req %0d/%0d",
                 $realtime, want.kind, got.kind, want.measured_bpm, got.measured_bpm,
                 $signed(want.requested_bpm), $signed(got.requested_bpm));
          $display(" ccn %0d/%0d ccv %0d/%0d ch %0d/%0d last %0b/%0b",
                   want.cc_number, got.cc_number, want.cc_value, got.cc_value,
                   want.cc_channel, got.cc_channel, want.last, got.last);
        end
        faults++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] message_type, [14:8] bpm_change
  logic [FUNC_W-1:0]     s_tuser = '0;   // [1:0] func
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [23:0] measured_bpm, [48:24] requested_bpm,
                                         // [55:49] cc_number, [62:56] cc_value,
                                         // [67:63] cc_channel
  logic [KIND_W-1:0]     m_tuser;        // [1:0] result_kind
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tempo_scoreboard scoreboard;
  int              sender_idle_pct = 0;
  int              sink_stall_pct = 0;
  int              counted_items = 0;   // non-ignored transactions sent so far

  midi_clock_tempo_meter_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sink back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_stall_pct);
  end

  // Every result transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind          = m_tuser;
      got.measured_bpm  = m_tdata[23:0];
      got.requested_bpm = m_tdata[48:24];
      got.cc_number     = m_tdata[55:49];
      got.cc_value      = m_tdata[62:56];
      got.cc_channel    = m_tdata[67:63];
      got.last          = m_tlast;
      scoreboard.check_result(got);
    end
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // All driver tasks start and end at a falling edge.
  task automatic push_item(input logic [FUNC_W-1:0] func, input logic [MSG_W-1:0] msg,
                           input logic [DELTA_W-1:0] delta);
    while ($urandom_range(99) < sender_idle_pct)
      @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = func;
    s_tdata  = {1'b0, delta, msg};
    do @(posedge clk); while (!s_tready);
    scoreboard.take_item(func, msg, delta);
    if (func == FUNC_TICK || func == FUNC_TEMPO || (func == FUNC_MIDI && msg == CLOCK_STATUS))
      counted_items++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic tick_run(input int n);
    repeat (n) push_item(FUNC_TICK, MSG_W'($urandom), DELTA_W'($urandom));
  endtask

  task automatic wait_drained(input int tail);
    int waited;
    waited = 0;
    while (scoreboard.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (tail) @(negedge clk);
  endtask

  // Bits above the register width carry random junk; the block must drop them.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                           input int width);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = (CFG_DATA_W'($urandom) << width) | value;
    @(posedge clk);
    scoreboard.set_reg(idx, cfg_data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input logic [CH_W-1:0] ch, input logic [CPM_W-1:0] cpm,
                           input logic [BPM_W-1:0] scale, input logic [CC_W-1:0] low,
                           input logic [CC_W-1:0] high);
    write_reg(CFG_CHANNEL, CFG_DATA_W'(ch), CH_W);
    write_reg(CFG_CPM, CFG_DATA_W'(cpm), CPM_W);
    write_reg(CFG_SCALE, scale, BPM_W);
    write_reg(CFG_LOW_CC, CFG_DATA_W'(low), CC_W);
    write_reg(CFG_HIGH_CC, CFG_DATA_W'(high), CC_W);
  endtask

  // Keeps sending clocks until the open measurement closes, spreading the
  // ticks over the clock gaps with the odd stray message in between.
  task automatic finish_measurement(input int ticks_total);
    int remaining;
    int left;
    int n;
    remaining = ticks_total;
    while (scoreboard.measuring) begin
      left = (scoreboard.clocks_per_measure > scoreboard.clock_count) ?
             int'(scoreboard.clocks_per_measure - scoreboard.clock_count) : 1;
      n = (left == 1) ? remaining : $urandom_range(0, (2 * remaining) / left);
      if (n > remaining)
        n = remaining;
      tick_run(n);
      remaining -= n;
      if ($urandom_range(9) == 0)
        push_item(FUNC_MIDI, MSG_W'($urandom), DELTA_W'($urandom));
      push_item(FUNC_MIDI, CLOCK_STATUS, DELTA_W'($urandom));
    end
  endtask

  task automatic random_phase(input int budget, input int ticks_nominal);
    int stop_at;
    int choice;
    int left;
    stop_at = counted_items + budget;
    while (counted_items < stop_at) begin
      choice = $urandom_range(99);
      if (choice < 65) begin
        // well-formed measurement followed by tempo requests on its result
        if (!scoreboard.measuring)
          push_item(FUNC_MIDI, CLOCK_STATUS, DELTA_W'($urandom));
        finish_measurement(($urandom_range(11) == 0) ? 0 :
                           $urandom_range(ticks_nominal / 2, (ticks_nominal * 3) / 2));
        repeat ($urandom_range(1, 4)) push_item(FUNC_TEMPO, MSG_W'($urandom), DELTA_W'($urandom));
        if ($urandom_range(9) == 0)
          wait_drained(0);
      end else if (choice < 80) begin
        repeat ($urandom_range(1, 3)) push_item(FUNC_TEMPO, MSG_W'($urandom), DELTA_W'($urandom));
      end else if (choice < 92) begin
        // noise: any function code, any message type
        repeat ($urandom_range(1, 4))
          push_item(FUNC_W'($urandom), MSG_W'($urandom), DELTA_W'($urandom));
      end else begin
        // broken run: some clocks, then leave the measurement open
        if (!scoreboard.measuring)
          push_item(FUNC_MIDI, CLOCK_STATUS, DELTA_W'($urandom));
        left = (scoreboard.clocks_per_measure > scoreboard.clock_count) ?
               int'(scoreboard.clocks_per_measure - scoreboard.clock_count) : 0;
        if (left > 1)
          repeat ($urandom_range(1, left - 1)) begin
            tick_run($urandom_range(0, 3));
            push_item(FUNC_MIDI, CLOCK_STATUS, DELTA_W'($urandom));
          end
      end
    end
  endtask

  initial begin
    logic [CH_W-1:0]  ch;
    logic [CPM_W-1:0] cpm;
    logic [BPM_W-1:0] scale;
    logic [CC_W-1:0]  low;
    logic [CC_W-1:0]  high;
    int               ticks_nominal;

    scoreboard = new();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    sender_idle_pct = 17;
    sink_stall_pct  = 17;

    // Directed, reset settings: no tempo measured yet, so requests sit near zero.
    push_item(FUNC_TEMPO, 8'h00, 7'h40);        // most negative delta, negative request
    push_item(FUNC_TEMPO, 8'hFF, 7'h00);        // request zero, out of range
    push_item(FUNC_TEMPO, 8'h00, 7'h3F);        // request 63, low range
    push_item(FUNC_SPARE, CLOCK_STATUS, 7'h7F); // unused code, dropped
    push_item(FUNC_MIDI, 8'h00, 7'h00);         // other message types are dropped
    push_item(FUNC_MIDI, 8'hFF, 7'h7F);
    tick_run(1);
    wait_drained(SETTLE_CYCLES);

    // Directed, one clock per measurement and extreme register values.
    configure(5'd16, 8'd1, 24'd1600, 7'd127, 7'd0);
    push_item(FUNC_MIDI, CLOCK_STATUS, 7'h00);  // opening clock
    push_item(FUNC_MIDI, CLOCK_STATUS, 7'h00);  // no time passed: saturated tempo
    push_item(FUNC_TEMPO, 8'h00, 7'h3F);        // sum clamps at the top
    push_item(FUNC_TEMPO, 8'h00, 7'h40);
    push_item(FUNC_MIDI, CLOCK_STATUS, 7'h00);
    tick_run(10);
    push_item(FUNC_MIDI, CLOCK_STATUS, 7'h00);  // 1600 / 10 ms = 160
    push_item(FUNC_TEMPO, 8'h00, 7'h00);        // exactly the split: two control changes
    push_item(FUNC_TEMPO, 8'h00, 7'h40);        // 96, low range
    push_item(FUNC_TEMPO, 8'h00, 7'h3F);        // 223, high range

    // Random phases, each with its own settings and one of four idle patterns.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained(SETTLE_CYCLES);
      ticks_nominal = $urandom_range(2, 20);
      ch    = CH_W'($urandom_range(1, 16));
      cpm   = CPM_W'($urandom_range(1, 12));
      scale = BPM_W'($urandom_range(30, 260) * ticks_nominal);
      low   = CC_W'($urandom);
      high  = CC_W'($urandom);
      case (phase)
        0: begin
          ch   = 5'd1;
          cpm  = 8'd1;
          low  = 7'd0;
          high = 7'd127;
        end
        1: begin
          ch  = 5'd16;
          cpm = 8'd255;
        end
        2: begin
          // out-of-range channel and clock limit, smallest scale
          ch    = 5'd0;
          cpm   = 8'd0;
          scale = 24'd1;
          low   = 7'd127;
          high  = 7'd0;
        end
        3: begin
          ch    = 5'd31;
          scale = MAX_BPM;
        end
        default: ;
      endcase
      configure(ch, cpm, scale, low, high);
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 55;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 55;
        end
        default: begin
          sender_idle_pct = 17;
          sink_stall_pct  = 17;
        end
      endcase
      random_phase(ITEMS_PER_PHASE, ticks_nominal);
    end

    wait_drained(SETTLE_CYCLES);
    if (scoreboard.pending_results.size() != 0) begin
      $display("%0d predicted results never arrived", scoreboard.pending_results.size());
      scoreboard.faults += scoreboard.pending_results.size();
    end
    if (scoreboard.faults == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
